// ===== src/tas_pkg.sv =====
// Shared widths, constants and types for the triangle alpha-shape test pipeline.
package tas_pkg;

    localparam int COORD_W  = 32;
    localparam int DIFF_W   = 33;
    localparam int SUM_W    = 34;
    localparam int PROD_W   = 66;
    localparam int SQ_W     = 65;
    localparam int DET_W    = 67;
    localparam int S2_W     = 68;
    localparam int ALPHA_W  = 16;
    localparam int ASQ_W    = 32;

    // wide multiplier: a in limbs of 32, b in limbs of 32
    localparam int LIMB_W   = 32;
    localparam int MUL_A_W  = 200;
    localparam int MUL_B_W  = 68;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int A_LIMBS  = (MUL_A_W + LIMB_W - 1) / LIMB_W;
    localparam int B_LIMBS  = (MUL_B_W + LIMB_W - 1) / LIMB_W;
    localparam int MUL_LAT  = 3;

    localparam int BC_W     = 2 * SQ_W;
    localparam int LHS_P_W  = 3 * SQ_W;
    localparam int LHS_W    = LHS_P_W + 20;
    localparam int RHS_P_W  = MUL_A_W + ASQ_W;
    localparam int RHS_W    = RHS_P_W + 2;
    localparam int DEGP_W   = DET_W - 1 + 20;

    localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd256;
    // 4*D < 5e-5*(S/3)^2  <=>  720000*D < S^2
    localparam logic [19:0] DEG_SCALE = 20'd720000;

    localparam int N_STAGES = 13;

    typedef struct packed {
        logic signed [DET_W-1:0] d;
        logic [SQ_W-1:0]         b;
        logic [SQ_W-1:0]         c;
        logic [SQ_W-1:0]         e;
        logic [S2_W-1:0]         s2;
    } t_front;

endpackage

// ===== src/tas_wmul.sv =====
// Three-stage unsigned wide multiplier built from 32x32 partial products.
module tas_wmul (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [tas_pkg::MUL_A_W-1:0] i_a,
    input  logic [tas_pkg::MUL_B_W-1:0] i_b,
    output logic [tas_pkg::MUL_P_W-1:0] o_p
);
    import tas_pkg::*;

    localparam int AX_W = A_LIMBS * LIMB_W;
    localparam int BX_W = B_LIMBS * LIMB_W;

    logic [AX_W-1:0]       a_ext;
    logic [BX_W-1:0]       b_ext;
    logic [2*LIMB_W-1:0]   r_pp [A_LIMBS*B_LIMBS];
    logic [MUL_P_W-1:0]    r_row [A_LIMBS];
    logic [MUL_P_W-1:0]    n_row [A_LIMBS];
    logic [MUL_P_W-1:0]    r_p;
    logic [MUL_P_W-1:0]    n_p;

    assign a_ext = AX_W'(i_a);
    assign b_ext = BX_W'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < A_LIMBS; i++) begin
                for (int j = 0; j < B_LIMBS; j++) begin
                    r_pp[i*B_LIMBS+j] <= a_ext[i*LIMB_W +: LIMB_W] * b_ext[j*LIMB_W +: LIMB_W];
                end
            end
        end
    end

    // one row per limb of a
    always_comb begin
        for (int i = 0; i < A_LIMBS; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < B_LIMBS; j++) begin
                n_row[i] = n_row[i] + (MUL_P_W'(r_pp[i*B_LIMBS+j]) << (LIMB_W*(i+j)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row <= n_row;
        end
    end

    always_comb begin
        n_p = '0;
        for (int i = 0; i < A_LIMBS; i++) begin
            n_p = n_p + r_row[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// ===== src/tas_front.sv =====
// Front stages: edge vectors, products, determinant, squared edges and size sum.
module tas_front (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [9*tas_pkg::COORD_W-1:0] i_tri,
    output tas_pkg::t_front             o_front
);
    import tas_pkg::*;

    logic signed [COORD_W-1:0] xa, ya, xb, yb, xc, yc;
    logic [COORD_W-1:0]        ha, hb, hc;

    logic signed [DIFF_W-1:0]  r_dx1, r_dy1, r_dx2, r_dy2, r_ex, r_ey;
    logic [SUM_W-1:0]          r_s;

    logic signed [PROD_W-1:0]  r_pd1, r_pd2;
    logic signed [PROD_W-1:0]  n_q0, n_q1, n_q2, n_q3, n_q4, n_q5;
    logic [SQ_W-2:0]           r_q0, r_q1, r_q2, r_q3, r_q4, r_q5;
    logic [S2_W-1:0]           r_s2;

    t_front                    r_front;

    assign xa = i_tri[0*COORD_W +: COORD_W];
    assign ya = i_tri[1*COORD_W +: COORD_W];
    assign xb = i_tri[2*COORD_W +: COORD_W];
    assign yb = i_tri[3*COORD_W +: COORD_W];
    assign xc = i_tri[4*COORD_W +: COORD_W];
    assign yc = i_tri[5*COORD_W +: COORD_W];
    assign ha = i_tri[6*COORD_W +: COORD_W];
    assign hb = i_tri[7*COORD_W +: COORD_W];
    assign hc = i_tri[8*COORD_W +: COORD_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx1 <= DIFF_W'(xb) - DIFF_W'(xa);
            r_dy1 <= DIFF_W'(yb) - DIFF_W'(ya);
            r_dx2 <= DIFF_W'(xc) - DIFF_W'(xa);
            r_dy2 <= DIFF_W'(yc) - DIFF_W'(ya);
            r_ex  <= DIFF_W'(xb) - DIFF_W'(xc);
            r_ey  <= DIFF_W'(yb) - DIFF_W'(yc);
            r_s   <= SUM_W'(ha) + SUM_W'(hb) + SUM_W'(hc);
        end
    end

    assign n_q0 = r_dx1 * r_dx1;
    assign n_q1 = r_dy1 * r_dy1;
    assign n_q2 = r_dx2 * r_dx2;
    assign n_q3 = r_dy2 * r_dy2;
    assign n_q4 = r_ex * r_ex;
    assign n_q5 = r_ey * r_ey;

    // squares are below 2^64, keep the low bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pd1 <= r_dx1 * r_dy2;
            r_pd2 <= r_dy1 * r_dx2;
            r_q0  <= n_q0[SQ_W-2:0];
            r_q1  <= n_q1[SQ_W-2:0];
            r_q2  <= n_q2[SQ_W-2:0];
            r_q3  <= n_q3[SQ_W-2:0];
            r_q4  <= n_q4[SQ_W-2:0];
            r_q5  <= n_q5[SQ_W-2:0];
            r_s2  <= S2_W'(r_s) * S2_W'(r_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_front.d  <= DET_W'(r_pd1) - DET_W'(r_pd2);
            r_front.b  <= SQ_W'(r_q0) + SQ_W'(r_q1);
            r_front.c  <= SQ_W'(r_q2) + SQ_W'(r_q3);
            r_front.e  <= SQ_W'(r_q4) + SQ_W'(r_q5);
            r_front.s2 <= r_s2;
        end
    end

    assign o_front = r_front;

endmodule

// ===== src/triangle_alpha_shape_test.sv =====
// Top level: alpha-shape circumradius test for one triangle per request.
//
//  channel   | dir | handshake             | payload
//  ----------+-----+-----------------------+------------------------------------------
//  s_axis    | in  | s_axis_tvalid/tready  | tdata[287:0]: x_a y_a x_b y_b x_c y_c h_a h_b h_c
//  m_axis    | out | m_axis_tvalid/tready  | tdata[7:0]: keep, degenerate, zeros
//  cfg       | in  | i_cfg_we              | i_cfg_wdata[15:0]: alpha
//
// One request per cycle while m_axis is not stalled; the pipeline runs through the three
// front stages, the longest chain of three wide multiplier units and a final compare register.
// All stages advance together; a stall on m_axis freezes the whole pipeline.
// Reset clears the stage valid bits and sets alpha to 1.0.
module triangle_alpha_shape_test (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [287:0] s_axis_tdata,   // x_a, y_a, x_b, y_b, x_c, y_c, h_a, h_b, h_c
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,   // keep, degenerate, zero fill
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata
);
    import tas_pkg::*;

    logic                  en;
    logic [N_STAGES-1:0]   r_vld;
    logic [ALPHA_W-1:0]    r_alpha;
    logic [ASQ_W-1:0]      r_alpha_sq;

    t_front                front;
    logic                  n_deg;
    logic [DEGP_W-1:0]     deg_prod;
    logic                  r_deg [4:12];
    logic [SQ_W-1:0]       r_e [4:6];
    logic [S2_W-1:0]       r_s2 [4:6];

    logic [MUL_P_W-1:0]    p_bc, p_dd, p_bce, p_dds, p_rhs;
    logic [LHS_P_W-1:0]    r_lp [10:12];

    logic [LHS_W-1:0]      lhs;
    logic [RHS_W-1:0]      rhs;
    logic                  r_keep, r_degen;

    assign en            = !r_vld[N_STAGES-1] || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_alpha <= ALPHA_RST;
        end else begin
            if (en) begin
                r_vld <= {r_vld[N_STAGES-2:0], s_axis_tvalid};
            end
            if (i_cfg_we) begin
                r_alpha <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_alpha_sq <= ASQ_W'(r_alpha) * ASQ_W'(r_alpha);
    end

    tas_front u_front (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_tri   (s_axis_tdata),
        .o_front (front)
    );

    // zero or negative area is always degenerate
    assign deg_prod = DEGP_W'(front.d[DET_W-2:0]) * DEGP_W'(DEG_SCALE);
    assign n_deg    = front.d[DET_W-1] || (front.d == '0) || (deg_prod < DEGP_W'(front.s2));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_deg[4] <= n_deg;
            r_e[4]   <= front.e;
            r_s2[4]  <= front.s2;
            for (int k = 5; k <= 6; k++) begin
                r_e[k]  <= r_e[k-1];
                r_s2[k] <= r_s2[k-1];
            end
            for (int k = 5; k <= 12; k++) begin
                r_deg[k] <= r_deg[k-1];
            end
            r_lp[10] <= p_bce[LHS_P_W-1:0];
            for (int k = 11; k <= 12; k++) begin
                r_lp[k] <= r_lp[k-1];
            end
        end
    end

    tas_wmul u_mul_bc (
        .i_clk (i_clk), .i_en (en),
        .i_a   (MUL_A_W'(front.b)), .i_b (MUL_B_W'(front.c)), .o_p (p_bc)
    );

    tas_wmul u_mul_dd (
        .i_clk (i_clk), .i_en (en),
        .i_a   (MUL_A_W'(front.d[DET_W-2:0])), .i_b (MUL_B_W'(front.d[DET_W-2:0])),
        .o_p   (p_dd)
    );

    tas_wmul u_mul_bce (
        .i_clk (i_clk), .i_en (en),
        .i_a   (MUL_A_W'(p_bc[BC_W-1:0])), .i_b (MUL_B_W'(r_e[6])), .o_p (p_bce)
    );

    tas_wmul u_mul_dds (
        .i_clk (i_clk), .i_en (en),
        .i_a   (MUL_A_W'(p_dd[2*(DET_W-1)-1:0])), .i_b (r_s2[6]), .o_p (p_dds)
    );

    tas_wmul u_mul_rhs (
        .i_clk (i_clk), .i_en (en),
        .i_a   (p_dds[MUL_A_W-1:0]), .i_b (MUL_B_W'(r_alpha_sq)), .o_p (p_rhs)
    );

    // 589824 = 2^19 + 2^16
    assign lhs = (LHS_W'(r_lp[12]) << 19) + (LHS_W'(r_lp[12]) << 16);
    assign rhs = {p_rhs[RHS_P_W-1:0], 2'b00};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_degen <= r_deg[12];
            r_keep  <= !r_deg[12] && (RHS_W'(lhs) < rhs);
        end
    end

    assign m_axis_tvalid = r_vld[N_STAGES-1];
    assign m_axis_tdata  = {6'b0, r_degen, r_keep};

    a_keep_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("keep and degenerate both set");

    a_alpha_rst: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_alpha == ALPHA_RST && r_vld == '0))
        else $error("reset state wrong");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(en)) |-> (r_vld[N_STAGES-1] == $past(r_vld[N_STAGES-2])))
        else $error("pipeline valid did not advance");

endmodule

// ===== tb/triangle_alpha_shape_test_tb.sv =====
// Testbench for the triangle alpha-shape test: random and directed triangles against a predictor.
module triangle_alpha_shape_test_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tas_pkg::*;

    typedef struct {
        logic signed [31:0] xa, ya, xb, yb, xc, yc;
        logic [31:0]        ha, hb, hc;
    } t_tri;

    typedef struct {
        logic keep;
        logic degenerate;
    } t_verdict;

    class verdict_board;
        t_verdict pending[$];
        logic [15:0] alpha_q;
        int errors;
        int mismatches;

        function new();
            alpha_q = ALPHA_RST;
            errors = 0;
            mismatches = 0;
        endfunction

        function t_verdict judge(t_tri t);
            logic signed [255:0] dx1, dy1, dx2, dy2, ex, ey, d, s2, lhs, rhs, sb, ab;
            t_verdict v;
            dx1 = $signed(t.xb) - $signed(t.xa);
            dy1 = $signed(t.yb) - $signed(t.ya);
            dx2 = $signed(t.xc) - $signed(t.xa);
            dy2 = $signed(t.yc) - $signed(t.ya);
            ex  = $signed(t.xb) - $signed(t.xc);
            ey  = $signed(t.yb) - $signed(t.yc);
            d   = dx1 * dy2 - dy1 * dx2;
            sb  = {222'd0, {2'b0, t.ha} + {2'b0, t.hb} + {2'b0, t.hc}};
            s2  = sb * sb;
            v.keep = 1'b0;
            v.degenerate = 1'b1;
            if (d > 0 && d * 256'sd720000 >= s2) begin
                lhs = (dx1 * dx1 + dy1 * dy1) * (dx2 * dx2 + dy2 * dy2)
                      * (ex * ex + ey * ey) * 256'sd589824;
                ab  = {240'd0, alpha_q};
                rhs = d * d * s2 * ab * ab * 256'sd4;
                v.keep = lhs < rhs;
                v.degenerate = 1'b0;
            end
            return v;
        endfunction

        function void note_request(t_tri t);
            pending = {pending, judge(t)};
        endfunction

        function void check_result(logic [7:0] data);
            t_verdict e;
            if (pending.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("Unexpected result %h", data);
                return;
            end
            e = pending.pop_front();
            if (data[0] !== e.keep || data[1] !== e.degenerate || data[7:2] !== 6'd0) begin
                errors++;
                if (mismatches++ < 10)
                    $display("Mismatch: expected keep=%b degenerate=%b, got tdata=%b",
                             e.keep, e.degenerate, data);
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [287:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic [15:0]  i_cfg_wdata = '0;

    verdict_board board = new();
    int src_idle = 0;
    int sink_stall = 0;
    int hold_off = 0;

    always #10 i_clk = ~i_clk;

    triangle_alpha_shape_test DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    // sink: stall at random, or hold off completely for a counted stretch
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    end

    // leave tvalid high after a request so that the next one can follow at once
    task automatic send_tri(t_tri t);
        while (src_idle > 0 && $urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  <= {t.hc, t.hb, t.ha, t.yc, t.xc, t.yb, t.xb, t.ya, t.xa};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_request(t);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_alpha(logic [15:0] a);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= a;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        board.alpha_q = a;
    endtask

    function automatic t_tri rand_tri();
        t_tri t;
        int unsigned mode;
        logic signed [31:0] bx, by;
        logic [31:0] hh;
        mode = $urandom_range(9);
        if (mode < 7) begin
            // well-formed: mostly counter-clockwise triangle near a base point; mode 6 swaps b and c
            bx = $urandom; by = $urandom;
            bx = bx >>> $urandom_range(8); by = by >>> $urandom_range(8);
            t.xa = bx; t.ya = by;
            t.xb = bx + ($urandom_range(32'h7ffff) >> $urandom_range(10)) + 1;
            t.yb = by + $signed($urandom_range(32'h3ffff)) - 32'sh1ffff;
            t.xc = bx + $signed($urandom_range(32'h7ffff)) - 32'sh3ffff;
            t.yc = by + ($urandom_range(32'h7ffff) >> $urandom_range(10)) + 32'sh20000;
            hh = ($urandom_range(32'hfffff) >> $urandom_range(12)) + 1;
            t.ha = hh + $urandom_range(4096);
            t.hb = hh + $urandom_range(4096);
            t.hc = hh + $urandom_range(4096);
            if (mode == 6) begin
                bx = t.xb; t.xb = t.xc; t.xc = bx;
                by = t.yb; t.yb = t.yc; t.yc = by;
            end
        end else begin
            t.xa = $urandom; t.ya = $urandom; t.xb = $urandom;
            t.yb = $urandom; t.xc = $urandom; t.yc = $urandom;
            t.ha = $urandom; t.hb = $urandom; t.hc = $urandom;
        end
        return t;
    endfunction

    function automatic t_tri mk(int xa, int ya, int xb, int yb, int xc, int yc,
                                int unsigned ha, int unsigned hb, int unsigned hc);
        t_tri t;
        t.xa = xa; t.ya = ya; t.xb = xb; t.yb = yb; t.xc = xc; t.yc = yc;
        t.ha = ha; t.hb = hb; t.hc = hc;
        return t;
    endfunction

    initial begin
        int k;
        int ph;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: unit triangle, clockwise, collinear, zero size, extremes
        send_tri(mk(0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000));
        send_tri(mk(0, 0, 0, 32'h10000, 32'h10000, 0, 32'h10000, 32'h10000, 32'h10000));
        send_tri(mk(0, 0, 32'h10000, 32'h10000, 32'h20000, 32'h20000, 0, 0, 0));
        send_tri(mk(0, 0, 32'h10000, 0, 0, 32'h10000, 0, 0, 0));
        send_tri(mk(0, 0, 32'h10000, 0, 0, 32'h10000, 32'h30000, 32'h30000, 32'h30000));
        send_tri(mk(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                    32'h80000000, 32'h7fffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff));
        send_tri(mk(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                    32'h80000000, 32'h7fffffff, 1, 1, 1));
        send_tri(mk(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                    32'h7fffffff, 32'h80000000, 32'h10000, 0, 0));
        send_tri(mk(0, 0, 1, 0, 0, 1, 32'hffffffff, 0, 0));
        send_tri(mk(0, 0, 1, 0, 0, 1, 0, 0, 1));
        send_tri(mk(5, 5, 5, 5, 5, 5, 0, 0, 0));
        write_alpha(16'hffff);
        send_tri(mk(0, 0, 32'h10000, 0, 0, 32'h10000, 32'h1000, 32'h1000, 32'h1000));
        write_alpha(16'd0);
        send_tri(mk(0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000));

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin src_idle = 0;  sink_stall = 0;  write_alpha(16'd256); end
                1: begin src_idle = 62; sink_stall = 0;  write_alpha(16'd1); end
                2: begin src_idle = 0;  sink_stall = 62; write_alpha(16'($urandom)); end
                3: begin src_idle = 31; sink_stall = 31; write_alpha(16'hffff); end
                default: begin
                    src_idle = 0; sink_stall = 0;
                    write_alpha(16'(16'd128 + $urandom_range(1024)));
                end
            endcase
            if (ph == 4) hold_off <= 60;
            for (k = 0; k < 108; k++) begin
                send_tri(rand_tri());
                if (k == 50) drain();
            end
        end

        drain();
        if (board.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && board.pending.size() == 0 && m_axis_tvalid === 1'bx) begin
            board.errors++;
        end
    end

    initial begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
src/tas_pkg.sv
src/tas_wmul.sv
src/tas_front.sv
src/triangle_alpha_shape_test.sv
tb/triangle_alpha_shape_test_tb.sv
